// File: hdl/elg_pkg.sv
package elg_pkg;

	// operand width of the modulus and all values
	localparam int W = 31;
	localparam int CNT_W = $clog2(W + 1);

	// register indexes of the configuration channel
	localparam logic [1:0] CFG_PRIME = 2'd0;
	localparam logic [1:0] CFG_GEN   = 2'd1;
	localparam logic [1:0] CFG_PUB   = 2'd2;

	// exponentiation selector: which base and exponent
	localparam logic [1:0] SEL_PUB = 2'd0;  // public_key ^ sig_r
	localparam logic [1:0] SEL_SIG = 2'd1;  // sig_r ^ sig_s
	localparam logic [1:0] SEL_GEN = 2'd2;  // generator ^ message

	// kinds of modular multiply
	localparam logic [1:0] MK_REDUCE = 2'd0;  // 1 * raw base -> base
	localparam logic [1:0] MK_RES    = 2'd1;  // res * base -> res
	localparam logic [1:0] MK_SQR    = 2'd2;  // base * base -> base
	localparam logic [1:0] MK_LEFT   = 2'd3;  // hold * res -> hold

	typedef struct packed {
		logic [W-1:0] sig_r;
		logic [W-1:0] sig_s;
		logic [W-1:0] message;
	} in_t;

	typedef struct packed {
		logic         verified;
		logic [W-1:0] left_side;
		logic [W-1:0] right_side;
	} out_t;

	typedef struct packed {
		logic       capture;
		logic       exp_init;
		logic [1:0] sel;
		logic       mul_start;
		logic [1:0] kind;
		logic       shift_exp;
		logic       save_hold;
		logic       save_right;
	} cmd_t;

	typedef struct packed {
		logic p_zero;
		logic mul_done;
		logic exp_zero;
		logic exp_lsb;
	} sts_t;

endpackage

// File: hdl/elg_datapath.sv
module elg_datapath (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [elg_pkg::W-1:0] prime,
	input  logic [elg_pkg::W-1:0] gen,
	input  logic [elg_pkg::W-1:0] pub,
	input  elg_pkg::in_t         item,
	input  elg_pkg::cmd_t        cmd,
	output elg_pkg::sts_t        sts,
	output elg_pkg::out_t        result
);

	localparam int W = elg_pkg::W;

	logic [W-1:0] r_q, s_q, m_q;
	logic         zero_q;
	logic [W-1:0] exp_q, base_q, res_q, hold_q, right_q;
	logic [W-1:0] acc_q, ma_q, mb_q;
	logic [elg_pkg::CNT_W-1:0] mcnt_q;
	logic         mrun_q;
	logic [1:0]   kind_q;

	logic [W:0]   dbl, sum;
	logic [W-1:0] dr, nr;
	logic [W-1:0] raw_base, exp_src, op_a, op_b;
	logic         last;

	// operand selection for a new exponentiation
	always_comb begin
		case (cmd.sel)
			elg_pkg::SEL_PUB: begin raw_base = pub; exp_src = r_q; end
			elg_pkg::SEL_SIG: begin raw_base = r_q; exp_src = s_q; end
			default:          begin raw_base = gen; exp_src = m_q; end
		endcase
	end

	// multiplier operands by kind
	always_comb begin
		case (cmd.kind)
			elg_pkg::MK_REDUCE: begin op_a = W'(1); op_b = raw_base; end
			elg_pkg::MK_RES:    begin op_a = res_q; op_b = base_q;   end
			elg_pkg::MK_SQR:    begin op_a = base_q; op_b = base_q;  end
			default:            begin op_a = hold_q; op_b = res_q;   end
		endcase
	end

	// one msb-first step of shift-and-add modular multiply
	always_comb begin
		dbl = {acc_q, 1'b0};
		dr  = (dbl >= {1'b0, prime}) ? W'(dbl - {1'b0, prime}) : W'(dbl);
		sum = {1'b0, dr} + (mb_q[W-1] ? {1'b0, ma_q} : '0);
		nr  = (sum >= {1'b0, prime}) ? W'(sum - {1'b0, prime}) : W'(sum);
	end

	assign last = mrun_q && (mcnt_q == elg_pkg::CNT_W'(1));

	// multiplier sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrun_q <= 1'b0;
			mcnt_q <= '0;
		end else if (cmd.mul_start) begin
			mrun_q <= 1'b1;
			mcnt_q <= elg_pkg::CNT_W'(W);
		end else if (mrun_q) begin
			mcnt_q <= mcnt_q - 1'b1;
			if (last) mrun_q <= 1'b0;
		end
	end

	// multiplier payload
	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			acc_q  <= '0;
			ma_q   <= op_a;
			mb_q   <= op_b;
			kind_q <= cmd.kind;
		end else if (mrun_q) begin
			acc_q <= nr;
			mb_q  <= {mb_q[W-2:0], 1'b0};
		end
	end

	// exponentiation registers and writeback
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			r_q    <= item.sig_r;
			s_q    <= item.sig_s;
			m_q    <= item.message;
			zero_q <= (prime == '0);
		end
		if (cmd.exp_init) begin
			exp_q <= exp_src;
			res_q <= W'(1);
		end
		if (cmd.shift_exp) exp_q <= {1'b0, exp_q[W-1:1]};
		if (cmd.save_hold) hold_q <= res_q;
		if (cmd.save_right) right_q <= res_q;
		if (last) begin
			case (kind_q)
				elg_pkg::MK_RES:  res_q <= nr;
				elg_pkg::MK_LEFT: hold_q <= nr;
				default:          base_q <= nr;
			endcase
		end
	end

	assign sts.p_zero   = (prime == '0);
	assign sts.mul_done = last;
	assign sts.exp_zero = (exp_q == '0);
	assign sts.exp_lsb  = exp_q[0];

	// result fields, all zero for a zero modulus
	assign result.left_side  = zero_q ? '0 : hold_q;
	assign result.right_side = zero_q ? '0 : right_q;
	assign result.verified   = zero_q ? 1'b0 : (hold_q == right_q);

endmodule

// File: hdl/elg_ctrl.sv
module elg_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  elg_pkg::sts_t sts,
	output elg_pkg::cmd_t cmd,
	output logic          busy,
	output logic          done
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_INIT  = 4'd1;
	localparam logic [3:0] ST_WRED  = 4'd2;
	localparam logic [3:0] ST_CHK   = 4'd3;
	localparam logic [3:0] ST_WRES  = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_WSQ   = 4'd6;
	localparam logic [3:0] ST_FIN   = 4'd7;
	localparam logic [3:0] ST_WLEFT = 4'd8;
	localparam logic [3:0] ST_DONE  = 4'd9;

	logic [3:0] state_q, state_d;
	logic [1:0] k_q, k_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		k_d     = k_q;
		cmd     = '0;
		cmd.sel = k_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					k_d = elg_pkg::SEL_PUB;
					state_d = sts.p_zero ? ST_DONE : ST_INIT;
				end
			end
			ST_INIT: begin
				cmd.exp_init  = 1'b1;
				cmd.mul_start = 1'b1;
				cmd.kind      = elg_pkg::MK_REDUCE;
				state_d = ST_WRED;
			end
			ST_WRED: if (sts.mul_done) state_d = ST_CHK;
			ST_CHK: begin
				if (sts.exp_zero) begin
					state_d = ST_FIN;
				end else if (sts.exp_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.kind = elg_pkg::MK_RES;
					state_d = ST_WRES;
				end else begin
					state_d = ST_SQ;
				end
			end
			ST_WRES: if (sts.mul_done) state_d = ST_SQ;
			ST_SQ: begin
				cmd.mul_start = 1'b1;
				cmd.kind = elg_pkg::MK_SQR;
				state_d = ST_WSQ;
			end
			ST_WSQ: begin
				if (sts.mul_done) begin
					cmd.shift_exp = 1'b1;
					state_d = ST_CHK;
				end
			end
			ST_FIN: begin
				unique case (k_q)
					elg_pkg::SEL_PUB: begin
						cmd.save_hold = 1'b1;
						k_d = elg_pkg::SEL_SIG;
						state_d = ST_INIT;
					end
					elg_pkg::SEL_SIG: begin
						cmd.mul_start = 1'b1;
						cmd.kind = elg_pkg::MK_LEFT;
						state_d = ST_WLEFT;
					end
					default: begin
						cmd.save_right = 1'b1;
						state_d = ST_DONE;
					end
				endcase
			end
			ST_WLEFT: begin
				if (sts.mul_done) begin
					k_d = elg_pkg::SEL_GEN;
					state_d = ST_INIT;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= elg_pkg::SEL_PUB;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

endmodule

// File: hdl/elgamal_signature_verify_unit.sv
// ElGamal signature check: left = pub^r * r^s mod p against right = g^m mod p.
// Configuration channel: cfg_valid/cfg_ready with cfg_index (0 prime modulus,
// 1 generator, 2 public key) and cfg_data; cfg_ready is always high and
// unknown indexes are dropped. Write only while busy is low.
// Input: a transaction is taken when start is high and busy is low; item
// carries sig_r, sig_s and message. busy stays high until the result.
// Output: done is high for one cycle with result (verified, left_side,
// right_side) valid in that cycle; the receiver cannot stall.
// Sequencing: one shared bit-serial modular multiplier, launched from a control
// state for each multiply. Each of the three exponentiations first reduces
// the base, then for each exponent bit up to the top set bit squares the base
// and, when the bit is set, first multiplies it into the result, then closes;
// the final left product adds one more multiply. A zero modulus raises done
// in the next cycle.
// busy falls the cycle after done, so items are handled one at a time.
// Reset: registers return to prime 23, generator 5, public key 1, idle.
module elgamal_signature_verify_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [elg_pkg::W-1:0] cfg_data,
	input  logic                  start,
	output logic                  busy,
	input  elg_pkg::in_t          item,
	output logic                  done,
	output elg_pkg::out_t         result
);

	localparam int W = elg_pkg::W;

	logic [W-1:0]  prime_q, gen_q, pub_q;
	elg_pkg::cmd_t cmd;
	elg_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_q <= W'(23);
			gen_q   <= W'(5);
			pub_q   <= W'(1);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				elg_pkg::CFG_PRIME: prime_q <= cfg_data;
				elg_pkg::CFG_GEN:   gen_q   <= cfg_data;
				elg_pkg::CFG_PUB:   pub_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	elg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	elg_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.prime  (prime_q),
		.gen    (gen_q),
		.pub    (pub_q),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.result (result)
	);

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");
	a_done_release: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy && !done) else $error("busy held after result");
	a_done_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.verified |-> result.left_side == result.right_side)
		else $error("verified with differing sides");
`endif

endmodule

// File: bench/elgamal_signature_verify_unit_tb.sv
`timescale 1ns / 100ps

module elgamal_signature_verify_unit_tb;

	localparam int W = elg_pkg::W;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam logic [W-1:0] MAX_VAL = '1;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct {
		longint unsigned p;
		longint unsigned g;
		longint unsigned y;
		longint unsigned x;
		bit signable;
		int n_items;
	} setting_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [W-1:0] cfg_data;
	logic start;
	logic busy;
	elg_pkg::in_t item;
	logic done;
	elg_pkg::out_t result;

	elg_pkg::in_t pending_sigs[$];
	elg_pkg::out_t expected_verdicts[$];
	logic [W-1:0] mod_p, gen_g, pub_y;
	logic took;
	int idle_pct;
	int sent_cnt, checked_cnt, match_cnt, mismatch_cnt;
	longint cycle_cnt;

	elgamal_signature_verify_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.start(start), .busy(busy), .item(item),
		.done(done), .result(result)
	);

	// clock
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// base^e mod m, running value starts at 1
	function automatic longint unsigned power_mod(longint unsigned base, longint unsigned e,
			longint unsigned m);
		longint unsigned acc;
		acc = 1;
		base = base % m;
		while (e != 0) begin
			if (e[0])
				acc = ((acc % m) * base) % m;
			base = (base * base) % m;
			e = e >> 1;
		end
		return acc;
	endfunction

	// expected check result under the current register values
	function automatic elg_pkg::out_t verdict_of(elg_pkg::in_t sig);
		elg_pkg::out_t o;
		longint unsigned p, lhs, rhs;
		p = mod_p;
		o = '0;
		if (p != 0) begin
			lhs = ((power_mod(pub_y, sig.sig_r, p) % p) *
				(power_mod(sig.sig_r, sig.sig_s, p) % p)) % p;
			rhs = power_mod(gen_g, sig.message, p);
			o.verified = (lhs == rhs);
			o.left_side = lhs[W-1:0];
			o.right_side = rhs[W-1:0];
		end
		return o;
	endfunction

	// exponent values: mostly short, some full width
	function automatic logic [W-1:0] rand_exponent();
		if ($urandom_range(99) < 12)
			return W'($urandom_range(MAX_VAL, 0));
		return W'($urandom_range((32'd1 << $urandom_range(9)) - 32'd1, 0));
	endfunction

	// driver: next transaction at the falling edge
	always @(negedge clk) begin
		if (!start || took) begin
			if (pending_sigs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				item <= pending_sigs.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: check results, record accepted transactions
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		took <= start && !busy;
		if (done) begin
			checked_cnt++;
			if (expected_verdicts.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected result %0d/%0d/%0d", result.verified,
						result.left_side, result.right_side);
			end else begin
				elg_pkg::out_t e;
				e = expected_verdicts.pop_front();
				if (e.verified !== result.verified || e.left_side !== result.left_side ||
						e.right_side !== result.right_side) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("mismatch: expected %0d/%0d/%0d actual %0d/%0d/%0d",
							e.verified, e.left_side, e.right_side,
							result.verified, result.left_side, result.right_side);
				end else begin
					match_cnt += e.verified;
				end
			end
		end
		if (start && !busy) begin
			expected_verdicts.push_back(verdict_of(item));
			sent_cnt++;
			idle_pct = (sent_cnt < 185) ? 37 : (sent_cnt < 370) ? 63 : 0;
		end
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic [W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			elg_pkg::CFG_PRIME: mod_p = val;
			elg_pkg::CFG_GEN: gen_g = val;
			elg_pkg::CFG_PUB: pub_y = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (pending_sigs.size() != 0 || expected_verdicts.size() != 0 || start || busy);
	endtask

	// a valid signature: r = g^k, m = x*r + k*s mod (p-1)
	task automatic push_signed(setting_t st);
		elg_pkg::in_t sig;
		longint unsigned k, s;
		k = $urandom_range(200);
		s = $urandom_range(32'd1 << $urandom_range(8));
		sig.sig_r = W'(power_mod(st.g, k, st.p));
		sig.sig_s = W'(s);
		sig.message = (st.p == 2) ? '0 : W'((st.x * sig.sig_r + k * s) % (st.p - 1));
		pending_sigs.push_back(sig);
	endtask

	task automatic push_sig(logic [W-1:0] r, logic [W-1:0] s, logic [W-1:0] m);
		elg_pkg::in_t sig;
		sig.sig_r = r;
		sig.sig_s = s;
		sig.message = m;
		pending_sigs.push_back(sig);
	endtask

	initial begin
		setting_t plan[$];
		setting_t st;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = elg_pkg::CFG_PRIME;
		cfg_data = '0;
		start = 1'b0;
		item = '0;
		took = 1'b0;
		idle_pct = 37;
		sent_cnt = 0;
		checked_cnt = 0;
		match_cnt = 0;
		mismatch_cnt = 0;
		cycle_cnt = 0;
		mod_p = W'(23);
		gen_g = W'(5);
		pub_y = W'(1);
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed set under the reset registers
		push_sig(31'd0, 31'd0, 31'd0);
		push_sig(MAX_VAL, MAX_VAL, MAX_VAL);
		push_sig(MAX_VAL, 31'd0, 31'd1);
		push_sig(31'd0, MAX_VAL, 31'd0);
		push_sig(31'd1, 31'd1, 31'd1);
		push_sig(31'd23, 31'd5, 31'd22);
		push_sig(31'd46, 31'd2, 31'd0);
		push_sig(31'h2aaa_aaaa, 31'h5555_5555, 31'h2aaa_aaaa);
		push_sig(31'h5555_5555, 31'h2aaa_aaaa, 31'h5555_5555);
		st = '{23, 5, 1, 0, 1'b1, 0};
		repeat (6) push_signed(st);
		wait_idle();

		// register settings: zero and one modulus, primes, non-prime, extremes
		plan.push_back('{0, 5, 7, 0, 1'b0, 30});
		plan.push_back('{1, 3, 0, 0, 1'b0, 40});
		plan.push_back('{2, 1, 0, 1, 1'b1, 40});
		plan.push_back('{23, 5, 0, 3, 1'b1, 70});
		plan.push_back('{251, 6, 0, 117, 1'b1, 70});
		plan.push_back('{100, 7, MAX_VAL, 0, 1'b0, 60});
		plan.push_back('{65521, 17, 0, 4001, 1'b1, 55});
		plan.push_back('{MAX_VAL, 7, 0, 123457, 1'b1, 25});
		plan.push_back('{MAX_VAL, MAX_VAL, 0, 0, 1'b0, 25});
		plan.push_back('{23, 0, 5, 0, 1'b0, 60});
		plan.push_back('{3, 2, 0, 1, 1'b1, 50});

		foreach (plan[i]) begin
			st = plan[i];
			if (st.signable)
				st.y = power_mod(st.g, st.x, st.p);
			cfg_write(elg_pkg::CFG_PRIME, W'(st.p));
			cfg_write(elg_pkg::CFG_GEN, W'(st.g));
			cfg_write(elg_pkg::CFG_PUB, W'(st.y));
			if (i == 0)
				cfg_write(CFG_UNUSED, 31'h1234_5678);
			for (int n = 0; n < st.n_items; n++) begin
				if (st.signable && $urandom_range(99) < 60)
					push_signed(st);
				else
					push_sig(rand_exponent(), rand_exponent(), rand_exponent());
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		$display("checked %0d signature checks over %0d register settings", checked_cnt,
			plan.size() + 1);
		$display("%0d verified, %0d mismatches", match_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && expected_verdicts.size() == 0 && checked_cnt == sent_cnt)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
hdl/elg_pkg.sv
hdl/elg_datapath.sv
hdl/elg_ctrl.sv
hdl/elgamal_signature_verify_unit.sv
bench/elgamal_signature_verify_unit_tb.sv
